### design/slx_pkg.sv
// slx_pkg: types, constants and helper functions of the streaming source lexer
// used by the lexer front, the record queue, the emitter and the top level
// no dependencies
package slx_pkg;

  localparam int LINE_WIDTH  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef logic [LINE_WIDTH-1:0]  line_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [QPTR_W-1:0]      qptr_t;
  typedef logic [QPTR_W:0]        qcnt_t;

  localparam line_t LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam cnt_t  CNT_MAX  = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_INT     = 3'd1,
    MODE_FLOAT   = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_COMMENT = 3'd5
  } mode_t;

  // record kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // token types
  localparam logic [3:0] TT_INT_LIT = 4'd0;
  localparam logic [3:0] TT_STR_LIT = 4'd1;
  localparam logic [3:0] TT_FLOAT   = 4'd2;
  localparam logic [3:0] TT_PLUS    = 4'd3;
  localparam logic [3:0] TT_EOF     = 4'd4;
  localparam logic [3:0] TT_INT_KW  = 4'd5;
  localparam logic [3:0] TT_EQUAL   = 4'd6;
  localparam logic [3:0] TT_IDENT   = 4'd7;
  localparam logic [3:0] TT_STR_KW  = 4'd8;
  localparam logic [3:0] TT_MUL     = 4'd9;
  localparam logic [3:0] TT_LPAREN  = 4'd10;
  localparam logic [3:0] TT_RPAREN  = 4'd11;
  localparam logic [3:0] TT_OVER_KW = 4'd12;
  localparam logic [3:0] TT_COMMA   = 4'd13;

  // error codes
  localparam logic [1:0] ERR_UNKNOWN   = 2'd0;
  localparam logic [1:0] ERR_UNTERM_ST = 2'd1;
  localparam logic [1:0] ERR_UNTERM_CM = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // keyword slots in the candidate mask
  localparam logic [1:0] KW_INT  = 2'd0;
  localparam logic [1:0] KW_STR  = 2'd1;
  localparam logic [1:0] KW_OVER = 2'd2;
  localparam logic [2:0] KW_ALL  = 3'b111;
  localparam logic [2:0] KW_POS_MAX = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  token_type;
    logic [7:0]  text_char;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] token_total;
    logic        failed;
  } rec_t;

  // one queue entry holds the one or two records of a source byte
  typedef struct packed {
    rec_t r0;
    rec_t r1;
    logic two;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      KW_INT:  n = 3'd3;
      KW_STR:  n = 3'd6;
      KW_OVER: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (k)
      KW_INT: begin
        case (pos)
          3'd0:    c = "i";
          3'd1:    c = "n";
          3'd2:    c = "t";
          default: c = CH_NUL;
        endcase
      end
      KW_STR: begin
        case (pos)
          3'd0:    c = "s";
          3'd1:    c = "t";
          3'd2:    c = "r";
          3'd3:    c = "i";
          3'd4:    c = "n";
          3'd5:    c = "g";
          default: c = CH_NUL;
        endcase
      end
      KW_OVER: begin
        case (pos)
          3'd0:    c = "o";
          3'd1:    c = "v";
          3'd2:    c = "e";
          3'd3:    c = "r";
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // drop keyword candidates that do not match c at pos
  function automatic logic [2:0] kw_advance(input logic [2:0] pos, input logic [2:0] cand,
                                            input logic [7:0] c);
    logic [2:0] nc;
    nc = cand;
    for (int k = 0; k < 3; k++) begin
      if (pos >= kw_len(2'(k)) || kw_char(2'(k), pos) != c)
        nc[k] = 1'b0;
    end
    return nc;
  endfunction

  function automatic logic [3:0] ident_type(input logic [2:0] pos, input logic [2:0] cand);
    logic [3:0] t;
    if (cand[KW_INT] && pos == kw_len(KW_INT))
      t = TT_INT_KW;
    else if (cand[KW_STR] && pos == kw_len(KW_STR))
      t = TT_STR_KW;
    else if (cand[KW_OVER] && pos == kw_len(KW_OVER))
      t = TT_OVER_KW;
    else
      t = TT_IDENT;
    return t;
  endfunction

  function automatic rec_t mk_rec(input logic [1:0] kind, input logic [3:0] tt,
                                  input logic [7:0] c, input logic [1:0] code,
                                  input logic [15:0] line);
    rec_t r;
    r.kind        = kind;
    r.token_type  = tt;
    r.text_char   = c;
    r.error_code  = code;
    r.line_number = line;
    r.token_total = 16'd0;
    r.failed      = 1'b0;
    return r;
  endfunction

endpackage

### design/slx_if.sv
// slx_if: valid/ready channel interfaces of the streaming source lexer
// source byte channel and result record channel; no dependencies
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface slx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  token_type;
  logic [7:0]  text_char;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic [15:0] token_total;
  logic        failed;
  logic        last;

  modport source (output valid, output kind, output token_type, output text_char,
                  output error_code, output line_number, output token_total,
                  output failed, output last, input ready);
  modport sink (input valid, input kind, input token_type, input text_char,
                input error_code, input line_number, input token_total,
                input failed, input last, output ready);
endinterface

### design/slx_front.sv
// slx_front: lexer front, classifies each source byte and updates lexer state
// builds the one or two records of the byte as a queue entry; uses slx_pkg
module slx_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_ch,
  output logic            in_ready,
  input  logic            q_full,
  output logic            push,
  output slx_pkg::entry_t push_entry
);

  slx_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]     kw_pos_r, kw_pos_nxt;
  logic [2:0]     kw_cand_r, kw_cand_nxt;
  slx_pkg::line_t line_r, line_nxt;
  slx_pkg::cnt_t  cnt_r, cnt_nxt;
  logic           err_r, err_nxt;

  logic           a_vld, b_vld, go_idle, is_end;
  slx_pkg::rec_t  a_rec, b_rec;
  slx_pkg::cnt_t  cnt_a, tot;
  logic           err_a;
  logic [15:0]    line16;
  logic           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign line16   = 16'(line_r);

  always_comb begin
    mode_nxt    = mode_r;
    kw_pos_nxt  = kw_pos_r;
    kw_cand_nxt = kw_cand_r;
    a_vld       = 1'b0;
    a_rec       = slx_pkg::mk_rec(slx_pkg::KIND_TEXT, slx_pkg::TT_INT_LIT, in_ch,
                                  slx_pkg::ERR_UNKNOWN, line16);
    b_vld       = 1'b0;
    b_rec       = a_rec;
    go_idle     = 1'b0;
    is_end      = 1'b0;
    tot         = cnt_r;

    // record from the current mode
    case (mode_r)
      slx_pkg::MODE_INT, slx_pkg::MODE_FLOAT: begin
        a_vld = 1'b1;
        if (slx_pkg::is_digit(in_ch) || in_ch == slx_pkg::CH_DOT) begin
          if (in_ch == slx_pkg::CH_DOT)
            mode_nxt = slx_pkg::MODE_FLOAT;
        end else begin
          a_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN,
                                  (mode_r == slx_pkg::MODE_FLOAT) ? slx_pkg::TT_FLOAT
                                                                  : slx_pkg::TT_INT_LIT,
                                  slx_pkg::CH_NUL, slx_pkg::ERR_UNKNOWN, line16);
          go_idle = 1'b1;
        end
      end
      slx_pkg::MODE_IDENT: begin
        a_vld = 1'b1;
        if (slx_pkg::is_alpha(in_ch) || slx_pkg::is_digit(in_ch) ||
            in_ch == slx_pkg::CH_UNDER) begin
          kw_cand_nxt = slx_pkg::kw_advance(kw_pos_r, kw_cand_r, in_ch);
          kw_pos_nxt  = (kw_pos_r == slx_pkg::KW_POS_MAX) ? kw_pos_r : kw_pos_r + 3'd1;
        end else begin
          a_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN,
                                  slx_pkg::ident_type(kw_pos_r, kw_cand_r),
                                  slx_pkg::CH_NUL, slx_pkg::ERR_UNKNOWN, line16);
          go_idle = 1'b1;
        end
      end
      slx_pkg::MODE_STRING: begin
        a_vld = 1'b1;
        if (in_ch == slx_pkg::CH_DQUOTE) begin
          a_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_STR_LIT,
                                  slx_pkg::CH_NUL, slx_pkg::ERR_UNKNOWN, line16);
          mode_nxt = slx_pkg::MODE_IDLE;
        end else if (in_ch == slx_pkg::CH_NUL) begin
          a_rec = slx_pkg::mk_rec(slx_pkg::KIND_ERROR, slx_pkg::TT_INT_LIT,
                                  slx_pkg::CH_NUL, slx_pkg::ERR_UNTERM_ST, line16);
          is_end = 1'b1;
        end
      end
      slx_pkg::MODE_COMMENT: begin
        if (in_ch == slx_pkg::CH_DOLLAR) begin
          mode_nxt = slx_pkg::MODE_IDLE;
        end else if (in_ch == slx_pkg::CH_NUL) begin
          a_vld = 1'b1;
          a_rec = slx_pkg::mk_rec(slx_pkg::KIND_ERROR, slx_pkg::TT_INT_LIT,
                                  slx_pkg::CH_NUL, slx_pkg::ERR_UNTERM_CM, line16);
          is_end = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase

    cnt_a = (a_vld && a_rec.kind == slx_pkg::KIND_TOKEN && cnt_r != slx_pkg::CNT_MAX)
            ? cnt_r + slx_pkg::cnt_t'(1) : cnt_r;
    err_a = err_r || (a_vld && a_rec.kind == slx_pkg::KIND_ERROR);

    // byte lexed as if idle
    if (go_idle) begin
      mode_nxt = slx_pkg::MODE_IDLE;
      b_vld    = 1'b1;
      case (in_ch)
        slx_pkg::CH_NUL: is_end = 1'b1;
        slx_pkg::CH_STAR:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_MUL, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_PLUS:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_PLUS, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_EQ:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_EQUAL, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_LPAREN:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_LPAREN, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_RPAREN:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_RPAREN, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_COMMA:
          b_rec = slx_pkg::mk_rec(slx_pkg::KIND_TOKEN, slx_pkg::TT_COMMA, slx_pkg::CH_NUL,
                                  slx_pkg::ERR_UNKNOWN, line16);
        slx_pkg::CH_DQUOTE: begin
          b_vld    = 1'b0;
          mode_nxt = slx_pkg::MODE_STRING;
        end
        slx_pkg::CH_DOLLAR: begin
          b_vld    = 1'b0;
          mode_nxt = slx_pkg::MODE_COMMENT;
        end
        default: begin
          if (slx_pkg::is_digit(in_ch)) begin
            mode_nxt = slx_pkg::MODE_INT;
          end else if (slx_pkg::is_alpha(in_ch)) begin
            mode_nxt    = slx_pkg::MODE_IDENT;
            kw_pos_nxt  = 3'd1;
            kw_cand_nxt = slx_pkg::kw_advance(3'd0, slx_pkg::KW_ALL, in_ch);
          end else if (!slx_pkg::is_space(in_ch)) begin
            b_rec = slx_pkg::mk_rec(slx_pkg::KIND_ERROR, slx_pkg::TT_INT_LIT, in_ch,
                                    slx_pkg::ERR_UNKNOWN, line16);
          end else begin
            b_vld = 1'b0;
          end
        end
      endcase
    end

    if (is_end) begin
      tot = (!err_a && cnt_a != slx_pkg::CNT_MAX) ? cnt_a + slx_pkg::cnt_t'(1) : cnt_a;
      b_vld = 1'b1;
      b_rec = slx_pkg::mk_rec(slx_pkg::KIND_END, slx_pkg::TT_EOF, slx_pkg::CH_NUL,
                              slx_pkg::ERR_UNKNOWN, line16);
      b_rec.token_total = 16'(tot);
      b_rec.failed      = err_a;
    end

    cnt_nxt = (b_vld && b_rec.kind == slx_pkg::KIND_TOKEN && cnt_a != slx_pkg::CNT_MAX)
              ? cnt_a + slx_pkg::cnt_t'(1) : cnt_a;
    err_nxt = err_a || (b_vld && b_rec.kind == slx_pkg::KIND_ERROR);
    line_nxt = (in_ch == slx_pkg::CH_NL && line_r != slx_pkg::LINE_MAX)
               ? line_r + slx_pkg::line_t'(1) : line_r;

    // end of input puts the lexer back to its reset state
    if (is_end) begin
      mode_nxt    = slx_pkg::MODE_IDLE;
      kw_pos_nxt  = 3'd0;
      kw_cand_nxt = slx_pkg::KW_ALL;
      line_nxt    = slx_pkg::line_t'(1);
      cnt_nxt     = '0;
      err_nxt     = 1'b0;
    end
  end

  assign push           = accept && (a_vld || b_vld);
  assign push_entry.two = a_vld && b_vld;
  assign push_entry.r0  = a_vld ? a_rec : b_rec;
  assign push_entry.r1  = b_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= slx_pkg::MODE_IDLE;
      kw_pos_r  <= 3'd0;
      kw_cand_r <= slx_pkg::KW_ALL;
      line_r    <= slx_pkg::line_t'(1);
      cnt_r     <= '0;
      err_r     <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      kw_pos_r  <= kw_pos_nxt;
      kw_cand_r <= kw_cand_nxt;
      line_r    <= line_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

### design/slx_queue.sv
// slx_queue: short entry queue between lexer front and record emitter
// holds slx_pkg::entry_t items; uses slx_pkg
module slx_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  slx_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_vld,
  output slx_pkg::entry_t head
);

  slx_pkg::entry_t mem [slx_pkg::QDEPTH];
  slx_pkg::qptr_t  wr_ptr_r, rd_ptr_r;
  slx_pkg::qcnt_t  count_r, count_nxt;
  logic            do_pop;

  assign full     = (count_r == slx_pkg::qcnt_t'(slx_pkg::QDEPTH));
  assign head_vld = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop)
      count_nxt = count_r + slx_pkg::qcnt_t'(1);
    else if (!push && do_pop)
      count_nxt = count_r - slx_pkg::qcnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + slx_pkg::qptr_t'(1);
      if (do_pop)
        rd_ptr_r <= rd_ptr_r + slx_pkg::qptr_t'(1);
      count_r <= count_nxt;
    end
  end

endmodule

### design/slx_back.sv
// slx_back: record emitter, sends the records of each queue entry one per transfer
// through an output register and marks the last one; uses slx_pkg
module slx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_vld,
  input  slx_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output slx_pkg::rec_t   out_rec,
  output logic            out_last
);

  logic          idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  slx_pkg::rec_t rec_r;
  logic          last_r;
  logic          load, sel_last;

  assign load     = head_vld && (!valid_r || out_ready);
  assign sel_last = idx_r || !head.two;
  assign pop      = load && sel_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = !sel_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= idx_r ? head.r1 : head.r0;
      last_r <= sel_last;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = rec_r;
  assign out_last  = last_r;

endmodule

### design/streaming_source_lexer.sv
// streaming_source_lexer: one source byte per transfer in, text/token/error/end records out
// path: a byte's records are written into the queue, then loaded into the output register,
//   from which they transfer out
// throughput: one byte per cycle into a 4-entry queue while it is not full; records leave one
//   per cycle while the sink is ready, so a byte with two records holds the output for both
// reset: synchronous active-low rst_n clears lexer state (line 1, counts 0) and queue
module streaming_source_lexer (
  input  logic             clk,
  input  logic             rst_n,
  slx_in_if.sink           in_chan,
  slx_out_if.source        out_chan
);

  logic            q_full, push, pop, head_vld;
  slx_pkg::entry_t push_entry, head;
  slx_pkg::rec_t   rec;

  slx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ch      (in_chan.ch),
    .in_ready   (in_chan.ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  slx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_vld   (head_vld),
    .head       (head)
  );

  slx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_rec   (rec),
    .out_last  (out_chan.last)
  );

  assign out_chan.kind        = rec.kind;
  assign out_chan.token_type  = rec.token_type;
  assign out_chan.text_char   = rec.text_char;
  assign out_chan.error_code  = rec.error_code;
  assign out_chan.line_number = rec.line_number;
  assign out_chan.token_total = rec.token_total;
  assign out_chan.failed      = rec.failed;

endmodule

### design/slx_checker.sv
// slx_checker: port-level checks of the streaming source lexer record channel
// bound to streaming_source_lexer; uses slx_pkg
module slx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [3:0]  token_type,
  input logic [1:0]  error_code,
  input logic [15:0] token_total,
  input logic        failed,
  input logic        last
);

  // a stalled record keeps its kind, type, total and last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(token_type) &&
      $stable(token_total) && $stable(last))
    else $error("stalled record changed");

  // end record carries eof and closes its byte
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == slx_pkg::KIND_END |-> token_type == slx_pkg::TT_EOF && last)
    else $error("malformed end record");

  // totals and failure flag appear on end records only
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != slx_pkg::KIND_END |-> token_total == 16'd0 && !failed)
    else $error("total or failed on non-end record");

  // an unterminated error record never closes a byte, the end record follows it
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == slx_pkg::KIND_ERROR && error_code != slx_pkg::ERR_UNKNOWN
      |-> !last)
    else $error("unterminated error not followed by end");

  // no record right after reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("record valid after reset");

endmodule

bind streaming_source_lexer slx_checker u_slx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .kind        (out_chan.kind),
  .token_type  (out_chan.token_type),
  .error_code  (out_chan.error_code),
  .token_total (out_chan.token_total),
  .failed      (out_chan.failed),
  .last        (out_chan.last)
);

### tb/tb_streaming_source_lexer.sv
// tb_streaming_source_lexer: self-checking bench for the streaming source lexer
// drives source bytes, predicts text/token/error/end records and compares them
// depends on slx_pkg, slx_if (slx_in_if, slx_out_if) and streaming_source_lexer
`timescale 1ns / 1ps

module tb_streaming_source_lexer;

  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    slx_pkg::rec_t rec;
    logic          last;
  } lex_result_t;

  logic clk;
  logic rst_n;

  slx_in_if  src_bus ();
  slx_out_if rec_bus ();

  streaming_source_lexer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (src_bus),
    .out_chan (rec_bus)
  );

  // stimulus and scoreboard storage
  logic [7:0]  source_bytes[$];
  lex_result_t lexer_expect[$];
  int          queued_count;
  int          errors;
  int          stuck_cycles;
  int          src_idle_pct;
  int          sink_stall_pct;

  // predicted lexer state
  slx_pkg::mode_t lx_mode;
  logic [47:0]    lx_word;
  int             lx_len;
  logic [15:0]    lx_line;
  logic [15:0]    lx_tokens;
  logic           lx_failed;
  int             produced;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void lexer_clear();
    lx_mode   = slx_pkg::MODE_IDLE;
    lx_word   = '0;
    lx_len    = 0;
    lx_line   = 16'd1;
    lx_tokens = 16'd0;
    lx_failed = 1'b0;
  endfunction

  function automatic void put_rec(input logic [1:0] kind, input logic [3:0] tt,
                                  input logic [7:0] txt, input logic [1:0] code,
                                  input logic [15:0] total, input logic fail);
    lex_result_t e;
    e.rec.kind        = kind;
    e.rec.token_type  = tt;
    e.rec.text_char   = txt;
    e.rec.error_code  = code;
    e.rec.line_number = lx_line;
    e.rec.token_total = total;
    e.rec.failed      = fail;
    e.last            = 1'b0;
    lexer_expect.push_back(e);
    produced++;
  endfunction

  function automatic void put_text(input logic [7:0] c);
    put_rec(slx_pkg::KIND_TEXT, slx_pkg::TT_INT_LIT, c, slx_pkg::ERR_UNKNOWN, 16'd0, 1'b0);
  endfunction

  function automatic void put_token(input logic [3:0] tt);
    put_rec(slx_pkg::KIND_TOKEN, tt, 8'd0, slx_pkg::ERR_UNKNOWN, 16'd0, 1'b0);
    if (lx_tokens != slx_pkg::CNT_MAX)
      lx_tokens++;
  endfunction

  function automatic void put_error(input logic [1:0] code, input logic [7:0] c);
    put_rec(slx_pkg::KIND_ERROR, slx_pkg::TT_INT_LIT, c, code, 16'd0, 1'b0);
    lx_failed = 1'b1;
  endfunction

  function automatic void put_end();
    logic [15:0] total;
    total = lx_tokens;
    // eof itself only counts on a clean input
    if (!lx_failed && total != slx_pkg::CNT_MAX)
      total++;
    put_rec(slx_pkg::KIND_END, slx_pkg::TT_EOF, 8'd0, slx_pkg::ERR_UNKNOWN, total,
            lx_failed);
    lexer_clear();
  endfunction

  function automatic void word_append(input logic [7:0] c);
    // length 7 marks a word longer than any keyword
    if (lx_len < 7) begin
      lx_word = {lx_word[39:0], c};
      lx_len++;
    end
  endfunction

  function automatic logic [3:0] word_type();
    if (lx_len == 3 && lx_word[23:0] == "int")
      return slx_pkg::TT_INT_KW;
    if (lx_len == 6 && lx_word == "string")
      return slx_pkg::TT_STR_KW;
    if (lx_len == 4 && lx_word[31:0] == "over")
      return slx_pkg::TT_OVER_KW;
    return slx_pkg::TT_IDENT;
  endfunction

  function automatic void start_lexeme(input logic [7:0] c);
    lx_mode = slx_pkg::MODE_IDLE;
    case (c)
      slx_pkg::CH_NUL:    put_end();
      slx_pkg::CH_STAR:   put_token(slx_pkg::TT_MUL);
      slx_pkg::CH_PLUS:   put_token(slx_pkg::TT_PLUS);
      slx_pkg::CH_EQ:     put_token(slx_pkg::TT_EQUAL);
      slx_pkg::CH_LPAREN: put_token(slx_pkg::TT_LPAREN);
      slx_pkg::CH_RPAREN: put_token(slx_pkg::TT_RPAREN);
      slx_pkg::CH_COMMA:  put_token(slx_pkg::TT_COMMA);
      slx_pkg::CH_DQUOTE: lx_mode = slx_pkg::MODE_STRING;
      slx_pkg::CH_DOLLAR: lx_mode = slx_pkg::MODE_COMMENT;
      default: begin
        if (digit_ch(c)) begin
          lx_mode = slx_pkg::MODE_INT;
          put_text(c);
        end else if (letter_ch(c)) begin
          lx_mode = slx_pkg::MODE_IDENT;
          lx_word = '0;
          lx_len  = 0;
          word_append(c);
          put_text(c);
        end else if (!blank_ch(c)) begin
          put_error(slx_pkg::ERR_UNKNOWN, c);
        end
      end
    endcase
  endfunction

  function automatic void lex_predict(input logic [7:0] c);
    produced = 0;
    case (lx_mode)
      slx_pkg::MODE_INT, slx_pkg::MODE_FLOAT: begin
        if (digit_ch(c) || c == slx_pkg::CH_DOT) begin
          if (c == slx_pkg::CH_DOT)
            lx_mode = slx_pkg::MODE_FLOAT;
          put_text(c);
        end else begin
          put_token(lx_mode == slx_pkg::MODE_FLOAT ? slx_pkg::TT_FLOAT
                                                   : slx_pkg::TT_INT_LIT);
          start_lexeme(c);
        end
      end
      slx_pkg::MODE_IDENT: begin
        if (letter_ch(c) || digit_ch(c) || c == slx_pkg::CH_UNDER) begin
          word_append(c);
          put_text(c);
        end else begin
          put_token(word_type());
          start_lexeme(c);
        end
      end
      slx_pkg::MODE_STRING: begin
        if (c == slx_pkg::CH_DQUOTE) begin
          put_token(slx_pkg::TT_STR_LIT);
          lx_mode = slx_pkg::MODE_IDLE;
        end else if (c == slx_pkg::CH_NUL) begin
          put_error(slx_pkg::ERR_UNTERM_ST, 8'd0);
          put_end();
        end else begin
          put_text(c);
        end
      end
      slx_pkg::MODE_COMMENT: begin
        if (c == slx_pkg::CH_DOLLAR) begin
          lx_mode = slx_pkg::MODE_IDLE;
        end else if (c == slx_pkg::CH_NUL) begin
          put_error(slx_pkg::ERR_UNTERM_CM, 8'd0);
          put_end();
        end
      end
      default: start_lexeme(c);
    endcase
    // records of a newline byte carry the line before it
    if (c == slx_pkg::CH_NL && lx_line != slx_pkg::LINE_MAX)
      lx_line++;
    if (produced > 0)
      lexer_expect[lexer_expect.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver: holds a byte until its transfer, idles at random between bytes
  always @(posedge clk) begin
    if (!rst_n) begin
      src_bus.valid <= 1'b0;
    end else if (!src_bus.valid || src_bus.ready) begin
      if (source_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        src_bus.valid <= 1'b1;
        src_bus.ch    <= source_bytes.pop_front();
      end else begin
        src_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      rec_bus.ready <= 1'b0;
    else
      rec_bus.ready <= $urandom_range(99) >= sink_stall_pct;
  end

  // monitor: results are checked before the byte of this edge is predicted
  always @(posedge clk) begin
    lex_result_t want;
    if (rst_n) begin
      if (rec_bus.valid && rec_bus.ready) begin
        if (lexer_expect.size() == 0) begin
          $display("%0t: unexpected record, kind %0d type %0d char %0d", $time,
                   rec_bus.kind, rec_bus.token_type, rec_bus.text_char);
          errors++;
        end else begin
          want = lexer_expect.pop_front();
          check_field("kind", want.rec.kind, rec_bus.kind);
          check_field("token_type", want.rec.token_type, rec_bus.token_type);
          check_field("text_char", want.rec.text_char, rec_bus.text_char);
          check_field("error_code", want.rec.error_code, rec_bus.error_code);
          check_field("line_number", want.rec.line_number, rec_bus.line_number);
          check_field("token_total", want.rec.token_total, rec_bus.token_total);
          check_field("failed", want.rec.failed, rec_bus.failed);
          check_field("last", want.last, rec_bus.last);
        end
      end
      if (src_bus.valid && src_bus.ready)
        lex_predict(src_bus.ch);
    end
  end

  // watchdog: counts cycles with work outstanding and no transfer
  always @(posedge clk) begin
    if (!rst_n || (src_bus.valid && src_bus.ready) || (rec_bus.valid && rec_bus.ready) ||
        (source_bytes.size() == 0 && !src_bus.valid && lexer_expect.size() == 0)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb_streaming_source_lexer: errors");
        $finish;
      end
    end
  end

  task automatic push_src(input logic [7:0] b);
    source_bytes.push_back(b);
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_src(s[i]);
  endtask

  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (digit_ch(b) || letter_ch(b) || blank_ch(b) ||
               b == slx_pkg::CH_STAR || b == slx_pkg::CH_PLUS || b == slx_pkg::CH_EQ ||
               b == slx_pkg::CH_LPAREN || b == slx_pkg::CH_RPAREN ||
               b == slx_pkg::CH_COMMA || b == slx_pkg::CH_DQUOTE ||
               b == slx_pkg::CH_DOLLAR);
    return b;
  endfunction

  function automatic logic [7:0] body_byte(input logic [7:0] stop);
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0)
        b = 8'($urandom_range(1, 255));
      else
        b = 8'($urandom_range(8'h20, 8'h7E));
    end while (b == stop);
    return b;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(25)) + ($urandom_range(1) ? "a" : "A");
  endfunction

  // mostly well-formed lexemes with random content, some noise and broken ends
  task automatic queue_random_source(input int budget);
    string near_kw[10] = '{"int", "string", "over", "in", "strin", "ove",
                           "ints", "strings", "overx", "Over"};
    int    start, pick, n;
    logic [7:0] opener;
    logic [7:0] ops[6] = '{slx_pkg::CH_STAR, slx_pkg::CH_PLUS, slx_pkg::CH_EQ,
                           slx_pkg::CH_LPAREN, slx_pkg::CH_RPAREN, slx_pkg::CH_COMMA};
    logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    start = queued_count;
    while (queued_count - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        n = $urandom_range(1, 4);
        push_src(8'($urandom_range("0", "9")));
        for (int i = 1; i < n; i++)
          push_src($urandom_range(3) == 0 ? slx_pkg::CH_DOT
                                          : 8'($urandom_range("0", "9")));
      end else if (pick < 35) begin
        if ($urandom_range(9) < 3) begin
          queue_text(near_kw[$urandom_range(9)]);
        end else begin
          push_src(rand_letter());
          n = $urandom_range(5);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
              0:       push_src(8'($urandom_range("0", "9")));
              1:       push_src(slx_pkg::CH_UNDER);
              default: push_src(rand_letter());
            endcase
          end
        end
      end else if (pick < 55) begin
        push_src(ops[$urandom_range(5)]);
      end else if (pick < 65) begin
        push_src(slx_pkg::CH_DQUOTE);
        n = $urandom_range(5);
        for (int i = 0; i < n; i++)
          push_src(body_byte(slx_pkg::CH_DQUOTE));
        push_src(slx_pkg::CH_DQUOTE);
      end else if (pick < 72) begin
        push_src(slx_pkg::CH_DOLLAR);
        n = $urandom_range(5);
        for (int i = 0; i < n; i++)
          push_src(body_byte(slx_pkg::CH_DOLLAR));
        push_src(slx_pkg::CH_DOLLAR);
      end else if (pick < 80) begin
        push_src(blanks[$urandom_range(5)]);
      end else if (pick < 88) begin
        push_src(slx_pkg::CH_NL);
      end else if (pick < 94) begin
        push_src(odd_byte());
      end else if (pick < 97) begin
        push_src(slx_pkg::CH_NUL);
      end else begin
        // input ends inside a string or a comment
        opener = $urandom_range(1) ? slx_pkg::CH_DQUOTE : slx_pkg::CH_DOLLAR;
        push_src(opener);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
          push_src(body_byte(opener));
        push_src(slx_pkg::CH_NUL);
      end
      if ($urandom_range(9) < 6)
        push_src(8'h20);
    end
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (source_bytes.size() > 0 || src_bus.valid || lexer_expect.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    rst_n          = 1'b0;
    src_bus.valid  = 1'b0;
    src_bus.ch     = 8'd0;
    rec_bus.ready  = 1'b0;
    errors         = 0;
    stuck_cycles   = 0;
    queued_count   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    lexer_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // keywords, every operator, both literals, float, comment, unknowns, blanks
    queue_text("string=(1.2*over),7\"\n\"+x_9$");
    push_src(8'hFF);
    queue_text("$_. ");
    push_src(8'h09);
    push_src(8'h0B);
    push_src(8'h0C);
    push_src(8'h0D);
    push_src(8'hFF);
    queue_text("int");
    push_src(slx_pkg::CH_NUL);
    queue_text("\"x");
    push_src(slx_pkg::CH_NUL);
    push_src(slx_pkg::CH_DOLLAR);
    push_src(slx_pkg::CH_NUL);
    wait_drained();

    set_idling(0, 0);
    queue_random_source(18);
    wait_drained();
    set_idling(73, 0);
    queue_random_source(18);
    wait_drained();
    set_idling(0, 73);
    queue_random_source(18);
    wait_drained();
    set_idling(17, 17);
    queue_random_source(18);
    push_src(slx_pkg::CH_NUL);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_streaming_source_lexer: clean");
    else
      $display("tb_streaming_source_lexer: errors");
    $finish;
  end

endmodule

### files.f
design/slx_pkg.sv
design/slx_if.sv
design/slx_front.sv
design/slx_queue.sv
design/slx_back.sv
design/streaming_source_lexer.sv
design/slx_checker.sv
tb/tb_streaming_source_lexer.sv
